// File: rtl/row_seat_allocator_core_assert.svh
// Assertion macros for the row seat allocator.
`ifndef ROW_SEAT_ALLOCATOR_CORE_ASSERT_SVH
`define ROW_SEAT_ALLOCATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RSA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("row seat allocator check failed");
`define RSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("row seat allocator check failed");
`else
`define RSA_ASSERT_IMPL(label, ante, cons)
`define RSA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/rsa_pkg.sv
// Shared constants and types for the row seat allocator.
package rsa_pkg;
  localparam int unsigned MAX_ROWS_DEF  = 1024;
  localparam int unsigned SEAT_BITS_DEF = 20;
  localparam int unsigned CNT_W         = 30;
  localparam int unsigned ROW_W         = 10;
  localparam int unsigned FSEAT_W       = 20;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 20;
  localparam int unsigned ROWS_CFG_W    = 11;
  localparam int unsigned ROWS_RST      = 1024;
  localparam int unsigned SEATS_RST     = 1048575;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEATS_PER_ROW = 1'b1;
  localparam logic CMD_CONTIG  = 1'b0;
  localparam logic CMD_SCATTER = 1'b1;
endpackage

// File: rtl/rsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module rsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/row_seat_allocator_core.sv
// Row seat allocator: first-fit row scan over a taken-seat count memory.
// Contiguous requests read and check each allowed row in order until one has room;
// scattered requests first sum the free seats of all allowed rows and, if these suffice,
// fill rows in order from row 0 until the request is met.
// One request at a time; the next input transfer can be taken in the cycle after the result transfer.
// After reset a clearing pass zeroes the memory, no input taken; config 1024/1048575.
module row_seat_allocator_core #(
  parameter int unsigned MAX_ROWS  = rsa_pkg::MAX_ROWS_DEF,
  parameter int unsigned SEAT_BITS = rsa_pkg::SEAT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [rsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // cmd
  input  logic [39:0] in_tdata,   // request_count[29:0], max_row[39:30]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // ok[0], granted_row[10:1], first_seat[30:11], pad
);
  localparam int unsigned AW = $clog2(MAX_ROWS);
  localparam int unsigned SUM_W = SEAT_BITS + AW + 1;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001, S_IDLE = 9'b000000010, S_SRD = 9'b000000100,
    S_SCHK = 9'b000001000, S_SUMRD = 9'b000010000, S_SUMACC = 9'b000100000,
    S_FRD = 9'b001000000, S_FWR = 9'b010000000, S_OUT = 9'b100000000
  } st_t;

  st_t st_r, st_nxt;
  logic [rsa_pkg::ROWS_CFG_W-1:0] rows_cfg_r;
  logic [rsa_pkg::CFG_DATA_W-1:0] seats_cfg_r;
  logic [AW:0]     row_r, row_nxt, end_r;
  logic            cmd_r;
  logic [rsa_pkg::CNT_W-1:0] left_r, left_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [31:0]     res_r, res_nxt;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [SEAT_BITS-1:0] wdata, rdata;
  logic [SEAT_BITS-1:0] cap, freev;
  logic [AW:0]     end_calc, rows_u;
  logic [AW:0]     maxr_p1;

  function automatic logic [rsa_pkg::FSEAT_W-1:0] FSEATX(input logic [SEAT_BITS-1:0] v);
    return rsa_pkg::FSEAT_W'(v);
  endfunction
  function automatic logic [rsa_pkg::ROW_W-1:0] ROWX(input logic [AW:0] v);
    return rsa_pkg::ROW_W'(v);
  endfunction

  rsa_ram #(.WIDTH(SEAT_BITS), .DEPTH(MAX_ROWS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    if ((rsa_pkg::CFG_DATA_W > SEAT_BITS) &&
        ((rsa_pkg::CFG_DATA_W+1)'(seats_cfg_r) >= ((rsa_pkg::CFG_DATA_W+1)'(1) << SEAT_BITS)))
      cap = '1;
    else
      cap = SEAT_BITS'(seats_cfg_r);
    freev = (cap > rdata) ? cap - rdata : '0;
    rows_u = ((32)'(rows_cfg_r) < MAX_ROWS) ? (AW+1)'(rows_cfg_r) : (AW+1)'(MAX_ROWS);
    maxr_p1 = (32'(in_tdata[39:30]) + 32'd1 >= MAX_ROWS) ? (AW+1)'(MAX_ROWS)
            : (AW+1)'(32'(in_tdata[39:30]) + 32'd1);
    end_calc = (maxr_p1 < rows_u) ? maxr_p1 : rows_u;
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = res_r;

  always_comb begin
    st_nxt = st_r; row_nxt = row_r; left_nxt = left_r; sum_nxt = sum_r; res_nxt = res_r;
    we = 1'b0; waddr = row_r[AW-1:0]; wdata = '0; raddr = row_r[AW-1:0];
    case (st_r)
      S_CLEAR: begin
        we = 1'b1;
        row_nxt = row_r + 1'b1;
        if (row_r == (AW+1)'(MAX_ROWS - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        raddr = '0;
        if (in_tvalid) begin
          row_nxt = '0; sum_nxt = '0; res_nxt = '0;
          left_nxt = in_tdata[29:0];
          if (in_tuser == rsa_pkg::CMD_CONTIG) st_nxt = S_SRD;
          else st_nxt = S_SUMRD;
        end
      end
      S_SRD: begin
        if (row_r >= end_r) st_nxt = S_OUT;
        else st_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (32'(freev) >= 32'(left_r)) begin
          we = 1'b1;
          wdata = SEAT_BITS'(32'(rdata) + 32'(left_r));
          res_nxt = {1'b0, FSEATX(rdata), ROWX(row_r), 1'b1};
          st_nxt = S_OUT;
        end else begin
          row_nxt = row_r + 1'b1;
          raddr = row_nxt[AW-1:0];
          st_nxt = S_SRD;
        end
      end
      S_SUMRD: begin
        if (row_r >= end_r) begin
          if (64'(sum_r) >= 64'(left_r)) begin
            res_nxt = 32'd1;
            row_nxt = '0;
            st_nxt = (left_r == '0) ? S_OUT : S_FRD;
          end else st_nxt = S_OUT;
        end else st_nxt = S_SUMACC;
      end
      S_SUMACC: begin
        sum_nxt = sum_r + SUM_W'(freev);
        row_nxt = row_r + 1'b1;
        raddr = row_nxt[AW-1:0];
        st_nxt = S_SUMRD;
      end
      S_FRD: begin
        if (row_r >= end_r || left_r == '0) st_nxt = S_OUT;
        else st_nxt = S_FWR;
      end
      S_FWR: begin
        if (32'(freev) >= 32'(left_r)) begin
          we = 1'b1;
          wdata = SEAT_BITS'(32'(rdata) + 32'(left_r));
          left_nxt = '0;
        end else if (freev != '0) begin
          we = 1'b1;
          wdata = rdata + freev;
          left_nxt = left_r - (rsa_pkg::CNT_W)'(freev);
        end
        row_nxt = row_r + 1'b1;
        raddr = row_nxt[AW-1:0];
        st_nxt = S_FRD;
      end
      S_OUT: begin
        if (out_tready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      row_r <= '0;
      rows_cfg_r <= (rsa_pkg::ROWS_CFG_W)'(rsa_pkg::ROWS_RST);
      seats_cfg_r <= (rsa_pkg::CFG_DATA_W)'(rsa_pkg::SEATS_RST);
    end else begin
      st_r <= st_nxt;
      row_r <= row_nxt;
      if (cfg_we && cfg_index == rsa_pkg::REG_ROWS_IN_USE)
        rows_cfg_r <= cfg_wdata[rsa_pkg::ROWS_CFG_W-1:0];
      if (cfg_we && cfg_index == rsa_pkg::REG_SEATS_PER_ROW)
        seats_cfg_r <= cfg_wdata;
    end
    left_r <= left_nxt;
    sum_r <= sum_nxt;
    res_r <= res_nxt;
    if (st_r == S_IDLE && in_tvalid) begin
      cmd_r <= in_tuser;
      end_r <= end_calc;
    end
  end

  `include "row_seat_allocator_core_assert.svh"
  `RSA_ASSERT_IMPL(a_no_in_when_busy, st_r != S_IDLE, !in_tready)
  `RSA_ASSERT_NEXT(a_out_after_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `RSA_ASSERT_IMPL(a_scatter_no_loc, out_tvalid && cmd_r == rsa_pkg::CMD_SCATTER, out_tdata[30:1] == '0)
endmodule

// File: tb/sv/tb_row_seat_allocator_core.sv
// Testbench for row_seat_allocator_core: random and directed requests checked against a predictor.
`timescale 1ns / 1ps

class seat_book_sb;
  typedef struct packed {
    logic        ok;
    logic [9:0]  row;
    logic [19:0] seat;
  } grant_t;

  int unsigned taken[1024];
  int unsigned rows_cfg;
  int unsigned seats_cfg;
  grant_t      pending[$];
  int          errors;

  function new();
    foreach (taken[i]) taken[i] = 0;
    rows_cfg  = rsa_pkg::ROWS_RST;
    seats_cfg = rsa_pkg::SEATS_RST;
    errors    = 0;
  endfunction

  function int unsigned free_in(int unsigned r);
    return (seats_cfg > taken[r]) ? seats_cfg - taken[r] : 0;
  endfunction

  // Work out the grant for one accepted request and update the seat counts.
  function void note_request(logic cmd, logic [29:0] want, logic [9:0] max_row);
    grant_t      g;
    int unsigned last_end;
    longint      total;
    longint      left;
    int unsigned f;
    g = '0;
    last_end = 32'(max_row) + 1;
    if (last_end > rows_cfg) last_end = rows_cfg;
    if (last_end > 1024) last_end = 1024;
    if (cmd == rsa_pkg::CMD_CONTIG) begin
      for (int unsigned r = 0; r < last_end; r++) begin
        if (free_in(r) >= want) begin
          g.ok   = 1'b1;
          g.row  = r[9:0];
          g.seat = taken[r][19:0];
          taken[r] += want;
          break;
        end
      end
    end else begin
      total = 0;
      for (int unsigned r = 0; r < last_end; r++) total += free_in(r);
      if (total >= want) begin
        left = want;
        for (int unsigned r = 0; r < last_end && left > 0; r++) begin
          f = free_in(r);
          if (f >= left) begin
            taken[r] += 32'(left);
            left = 0;
          end else if (f > 0) begin
            taken[r] += f;
            left -= f;
          end
        end
        g.ok = 1'b1;
      end
    end
    pending.push_back(g);
  endfunction

  function void check_grant(logic ok, logic [9:0] row, logic [19:0] seat);
    grant_t g;
    if (pending.size() == 0) begin
      $error("unexpected result transfer: ok=%0d row=%0d seat=%0d", ok, row, seat);
      errors++;
      return;
    end
    g = pending.pop_front();
    if (ok !== g.ok) begin
      $error("ok: expected %0d, actual %0d", g.ok, ok);
      errors++;
    end
    if (row !== g.row) begin
      $error("granted_row: expected %0d, actual %0d", g.row, row);
      errors++;
    end
    if (seat !== g.seat) begin
      $error("first_seat: expected %0d, actual %0d", g.seat, seat);
      errors++;
    end
  endfunction
endclass

module tb_row_seat_allocator_core;
  localparam longint CYCLE_LIMIT = 20000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [rsa_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rsa_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic        in_tuser;   // cmd
  logic [39:0] in_tdata;   // request_count[29:0], max_row[39:30]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // ok[0], granted_row[10:1], first_seat[30:11], pad

  seat_book_sb book;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          drain_each;
  longint      cycles;

  row_seat_allocator_core DUT (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    if (rst_n && in_tvalid && in_tready)
      book.note_request(in_tuser, in_tdata[29:0], in_tdata[39:30]);
    if (rst_n && out_tvalid && out_tready)
      book.check_grant(out_tdata[0], out_tdata[10:1], out_tdata[30:11]);
  end

  task automatic write_reg(logic [rsa_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[rsa_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rsa_pkg::REG_ROWS_IN_USE) book.rows_cfg = val & 32'h7FF;
    else book.seats_cfg = val & 32'hFFFFF;
  endtask

  task automatic wait_drained();
    while (book.pending.size() != 0) @(posedge clk);
  endtask

  // One request transfer; in_tvalid stays high if the next one follows at once.
  task automatic send_request(logic cmd, logic [29:0] want, logic [9:0] max_row);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {max_row, want};
    do @(posedge clk); while (!in_tready);
    if (drain_each) begin
      in_tvalid <= 1'b0;
      // let the monitor note the transfer before polling
      @(posedge clk);
      wait_drained();
    end else if ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
  endtask

  task automatic end_phase();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait_drained();
    repeat (4) @(posedge clk);
  endtask

  task automatic random_request();
    logic [29:0] want;
    logic [9:0]  max_row;
    int unsigned pick;
    int unsigned seats;
    seats = book.seats_cfg;
    pick  = $urandom_range(99, 0);
    if (pick < 8)       want = 30'($urandom());
    else if (pick < 16) want = 30'(seats);
    else if (pick < 24) want = 30'(seats * $urandom_range(4, 1));
    else if (pick < 28) want = 30'(seats + 1);
    else                want = 30'($urandom_range((seats > 4) ? seats / 4 : 1, 1));
    if ($urandom_range(1, 0)) max_row = 10'($urandom_range(1023, 0));
    else max_row = 10'($urandom_range(book.rows_cfg - 1, 0));
    send_request(1'($urandom_range(1, 0)), want, max_row);
  endtask

  int unsigned ph_rows [8] = '{1, 16, 1024, 64, 8, 1024, 3, 200};
  int unsigned ph_seats[8] = '{1, 10, 3, 1000, 1048575, 1048575, 7, 50};
  int unsigned ph_items[8] = '{200, 250, 30, 250, 300, 40, 250, 300};

  initial begin
    book           = new();
    cycles         = 0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = rsa_pkg::REG_ROWS_IN_USE;
    cfg_wdata      = '0;
    in_tvalid      = 1'b0;
    in_tuser       = rsa_pkg::CMD_CONTIG;
    in_tdata       = '0;
    out_tready     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain_each     = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset configuration
    send_request(rsa_pkg::CMD_CONTIG, 30'd1, 10'd0);
    send_request(rsa_pkg::CMD_CONTIG, 30'd1048574, 10'd0);
    send_request(rsa_pkg::CMD_CONTIG, 30'd1, 10'd0);
    send_request(rsa_pkg::CMD_CONTIG, 30'd1, 10'd1023);
    send_request(rsa_pkg::CMD_CONTIG, 30'd1048575, 10'd1023);
    send_request(rsa_pkg::CMD_CONTIG, 30'd1048576, 10'd1023);
    send_request(rsa_pkg::CMD_CONTIG, 30'd0, 10'd5);
    send_request(rsa_pkg::CMD_SCATTER, 30'd0, 10'd0);
    send_request(rsa_pkg::CMD_SCATTER, 30'h3FFFFFFF, 10'd1023);
    send_request(rsa_pkg::CMD_SCATTER, 30'd2097150, 10'd3);
    send_request(rsa_pkg::CMD_SCATTER, 30'd5, 10'd2);
    send_request(rsa_pkg::CMD_CONTIG, 30'd1048575, 10'd3);
    send_request(rsa_pkg::CMD_CONTIG, 30'd3, 10'd1023);
    send_request(rsa_pkg::CMD_SCATTER, 30'd1048575, 10'd1023);
    end_phase();

    foreach (ph_rows[p]) begin
      write_reg(rsa_pkg::REG_ROWS_IN_USE, ph_rows[p]);
      write_reg(rsa_pkg::REG_SEATS_PER_ROW, ph_seats[p]);
      send_idle_pct  = (p % 4 == 1) ? 85 : (p % 4 == 3) ? 24 : 0;
      recv_stall_pct = (p % 4 == 2) ? 85 : (p % 4 == 3) ? 24 : 0;
      drain_each     = (p == 4);
      // shrunk rows can leave taken counts above the new row size
      if (p == 6) send_request(rsa_pkg::CMD_CONTIG, 30'd0, 10'd1023);
      repeat (ph_items[p]) random_request();
      end_phase();
    end

    repeat (20) @(posedge clk);
    if (book.errors == 0 && book.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// File: row_seat_allocator_core.f
+incdir+rtl
rtl/rsa_pkg.sv
rtl/rsa_ram.sv
rtl/row_seat_allocator_core.sv
tb/sv/tb_row_seat_allocator_core.sv
